[hdl/pbn_pkg.sv]
package pbn_pkg;

	localparam int COMP_W     = 16;
	localparam int TRANS_W    = 32;
	localparam int THRESH_W   = 30;
	localparam int FRAC_BITS  = 12;
	localparam int SQRT_STEPS = 24;
	localparam int DIV_STEPS  = 14;
	// squares, sum, sqrt steps, divide prep, divide steps, output reg
	localparam int NORM_LAT   = SQRT_STEPS + DIV_STEPS + 4;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 30'd16777;

	typedef logic signed [COMP_W-1:0]  comp_t;
	typedef logic signed [TRANS_W-1:0] trans_t;

	localparam comp_t COMP_MAX = 16'sh7FFF;
	localparam comp_t COMP_MIN = 16'sh8000;

	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
	} vec3_t;

	typedef struct packed {
		comp_t  normal_x;
		comp_t  normal_y;
		comp_t  normal_z;
		trans_t translation_x;
		trans_t translation_y;
		trans_t translation_z;
	} in_t;

	typedef struct packed {
		comp_t  first_axis_x;
		comp_t  first_axis_y;
		comp_t  first_axis_z;
		comp_t  second_axis_x;
		comp_t  second_axis_y;
		comp_t  second_axis_z;
		comp_t  back_axis_x;
		comp_t  back_axis_y;
		comp_t  back_axis_z;
		trans_t origin_x;
		trans_t origin_y;
		trans_t origin_z;
	} out_t;

	function automatic comp_t neg_sat(comp_t v);
		return (v == COMP_MIN) ? COMP_MAX : comp_t'(-v);
	endfunction

	function automatic comp_t sat16(logic signed [21:0] v);
		if (v > 22'sd32767) begin
			return COMP_MAX;
		end
		if (v < -22'sd32768) begin
			return COMP_MIN;
		end
		return v[15:0];
	endfunction

endpackage

[hdl/pbn_norm.sv]
module pbn_norm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  pbn_pkg::vec3_t in_vec,
	output logic          out_valid,
	output pbn_pkg::vec3_t out_vec
);
	import pbn_pkg::*;

	comp_t v [3];
	assign v[0] = in_vec.x;
	assign v[1] = in_vec.y;
	assign v[2] = in_vec.z;

	// squares and magnitudes
	logic [30:0] sq_s1  [3];
	logic [15:0] mag_s1 [3];
	logic [2:0]  neg_s1;
	logic        vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i]  <= 31'(v[i] * v[i]);
				mag_s1[i] <= v[i][15] ? 16'(-v[i]) : 16'(v[i]);
				neg_s1[i] <= v[i][15];
			end
		end
	end

	// square root of len2 * 2^16, one result bit per stage
	logic [47:0] sx_s    [SQRT_STEPS+1];
	logic [27:0] srem_s  [SQRT_STEPS+1];
	logic [23:0] sroot_s [SQRT_STEPS+1];
	logic [15:0] smag_s  [SQRT_STEPS+1][3];
	logic [2:0]  sneg_s  [SQRT_STEPS+1];
	logic        szero_s [SQRT_STEPS+1];
	logic        sval_s  [SQRT_STEPS+1];

	logic [31:0] len_sum;
	assign len_sum = 32'(sq_s1[0]) + 32'(sq_s1[1]) + 32'(sq_s1[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sval_s[0] <= 1'b0;
		end else if (en) begin
			sval_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s[0]    <= {len_sum, 16'b0};
			srem_s[0]  <= '0;
			sroot_s[0] <= '0;
			smag_s[0]  <= mag_s1;
			sneg_s[0]  <= neg_s1;
			szero_s[0] <= (len_sum == 32'd0);
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [27:0] rem_sh;
		logic [27:0] trial;
		logic        fit;

		assign rem_sh = {srem_s[k][25:0], sx_s[k][47:46]};
		assign trial  = {2'b00, sroot_s[k], 2'b01};
		assign fit    = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sval_s[k+1] <= 1'b0;
			end else if (en) begin
				sval_s[k+1] <= sval_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sx_s[k+1]    <= sx_s[k] << 2;
				srem_s[k+1]  <= fit ? (rem_sh - trial) : rem_sh;
				sroot_s[k+1] <= {sroot_s[k][22:0], fit};
				smag_s[k+1]  <= smag_s[k];
				sneg_s[k+1]  <= sneg_s[k];
				szero_s[k+1] <= szero_s[k];
			end
		end
	end

	// rounded quotient (mag * 2^20 + r/2) / r, restoring, one bit per stage
	logic [37:0]          drem_s  [DIV_STEPS+1][3];
	logic [DIV_STEPS-1:0] dq_s    [DIV_STEPS+1][3];
	logic [23:0]          dd_s    [DIV_STEPS+1];
	logic [2:0]           dneg_s  [DIV_STEPS+1];
	logic                 dzero_s [DIV_STEPS+1];
	logic                 dval_s  [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dval_s[0] <= 1'b0;
		end else if (en) begin
			dval_s[0] <= sval_s[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				drem_s[0][i] <= 38'({smag_s[SQRT_STEPS][i], 20'b0})
					+ 38'(sroot_s[SQRT_STEPS][23:1]);
				dq_s[0][i]   <= '0;
			end
			dd_s[0]    <= sroot_s[SQRT_STEPS];
			dneg_s[0]  <= sneg_s[SQRT_STEPS];
			dzero_s[0] <= szero_s[SQRT_STEPS];
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [37:0] dsh;
		logic [2:0]  fit;

		assign dsh = 38'(dd_s[j]) << (DIV_STEPS - 1 - j);
		for (genvar i = 0; i < 3; i++) begin : g_lane
			assign fit[i] = (drem_s[j][i] >= dsh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dval_s[j+1] <= 1'b0;
			end else if (en) begin
				dval_s[j+1] <= dval_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					drem_s[j+1][i] <= fit[i] ? (drem_s[j][i] - dsh) : drem_s[j][i];
					dq_s[j+1][i]   <= {dq_s[j][i][DIV_STEPS-2:0], fit[i]};
				end
				dd_s[j+1]    <= dd_s[j];
				dneg_s[j+1]  <= dneg_s[j];
				dzero_s[j+1] <= dzero_s[j];
			end
		end
	end

	// apply sign; quotient stays below 2^14 so no clamp is reached
	comp_t res [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dzero_s[DIV_STEPS]) begin
				res[i] = '0;
			end else if (dneg_s[DIV_STEPS][i]) begin
				res[i] = comp_t'(-$signed({2'b00, dq_s[DIV_STEPS][i]}));
			end else begin
				res[i] = comp_t'({2'b00, dq_s[DIV_STEPS][i]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dval_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_vec.x <= res[0];
			out_vec.y <= res[1];
			out_vec.z <= res[2];
		end
	end

endmodule

[hdl/plane_basis_from_normal.sv]
// Throughput: one item per cycle; the pipeline advances whenever the output
// register is empty or its result is being taken, else every stage holds.
// Each normalize runs a 24-step square root and a 14-step divider, one step per stage.
// Reset clears all valid bits and loads the default parallel threshold.
module plane_basis_from_normal (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  pbn_pkg::in_t                       in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output pbn_pkg::out_t                      out_data,
	input  logic                               cfg_we,
	input  logic [pbn_pkg::THRESH_W-1:0]       cfg_wdata
);
	import pbn_pkg::*;

	typedef struct packed {
		vec3_t  n;
		trans_t tx;
		trans_t ty;
		trans_t tz;
		vec3_t  a1;
	} side_t;

	logic en;
	logic [THRESH_W-1:0] thresh_q;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	// s1: capture input
	side_t side_s1;
	logic  vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.n  <= '{in_data.normal_x, in_data.normal_y, in_data.normal_z};
			side_s1.tx <= in_data.translation_x;
			side_s1.ty <= in_data.translation_y;
			side_s1.tz <= in_data.translation_z;
			side_s1.a1 <= '0;
		end
	end

	// s2: squared length terms of the X-cross axis (0, nz, -ny)
	side_t       side_s2;
	comp_t       negy_s2;
	logic [30:0] sqz_s2;
	logic [30:0] sqy_s2;
	logic        vld_s2;
	comp_t       negy;

	assign negy = neg_sat(side_s1.n.y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			negy_s2 <= negy;
			sqz_s2  <= 31'(side_s1.n.z * side_s1.n.z);
			sqy_s2  <= 31'(negy * negy);
		end
	end

	// s3: pick the axis
	side_t       side_s3;
	vec3_t       axis_s3;
	logic        vld_s3;
	logic [31:0] len_x;

	assign len_x = 32'(sqz_s2) + 32'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			if (len_x <= 32'(thresh_q)) begin
				axis_s3 <= '{neg_sat(side_s2.n.z), '0, side_s2.n.x};
			end else begin
				axis_s3 <= '{'0, side_s2.n.z, negy_s2};
			end
		end
	end

	// first normalize, sideband delayed alongside
	logic  n1_valid;
	vec3_t n1_vec;
	side_t side1_s [NORM_LAT+1];

	pbn_norm u_norm1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.in_vec   (axis_s3),
		.out_valid(n1_valid),
		.out_vec  (n1_vec)
	);

	assign side1_s[0] = side_s3;
	for (genvar k = 0; k < NORM_LAT; k++) begin : g_side1
		always_ff @(posedge clk) begin
			if (en) begin
				side1_s[k+1] <= side1_s[k];
			end
		end
	end

	// x1: cross products of first axis with the normal
	side_t              side_x1;
	logic signed [31:0] prod_x1 [6];
	logic               vld_x1;
	vec3_t              nn;

	assign nn = side1_s[NORM_LAT].n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_x1 <= 1'b0;
		end else if (en) begin
			vld_x1 <= n1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_x1    <= '{nn, side1_s[NORM_LAT].tx, side1_s[NORM_LAT].ty,
				side1_s[NORM_LAT].tz, n1_vec};
			prod_x1[0] <= n1_vec.y * nn.z;
			prod_x1[1] <= n1_vec.z * nn.y;
			prod_x1[2] <= n1_vec.z * nn.x;
			prod_x1[3] <= n1_vec.x * nn.z;
			prod_x1[4] <= n1_vec.x * nn.y;
			prod_x1[5] <= n1_vec.y * nn.x;
		end
	end

	// x2: difference, round to Q3.12 (floor of +half), saturate
	side_t side_x2;
	vec3_t cross_x2;
	logic  vld_x2;
	comp_t cr [3];

	always_comb begin
		logic signed [33:0] d;
		for (int i = 0; i < 3; i++) begin
			d = 34'(prod_x1[2*i]) - 34'(prod_x1[2*i+1]) + 34'sd2048;
			cr[i] = sat16(22'(d >>> FRAC_BITS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_x2 <= 1'b0;
		end else if (en) begin
			vld_x2 <= vld_x1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_x2  <= side_x1;
			cross_x2 <= '{cr[0], cr[1], cr[2]};
		end
	end

	// second normalize
	logic  n2_valid;
	vec3_t n2_vec;
	side_t side2_s [NORM_LAT+1];

	pbn_norm u_norm2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_x2),
		.in_vec   (cross_x2),
		.out_valid(n2_valid),
		.out_vec  (n2_vec)
	);

	assign side2_s[0] = side_x2;
	for (genvar k = 0; k < NORM_LAT; k++) begin : g_side2
		always_ff @(posedge clk) begin
			if (en) begin
				side2_s[k+1] <= side2_s[k];
			end
		end
	end

	// output register
	side_t so;
	assign so = side2_s[NORM_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= n2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.first_axis_x  <= so.a1.x;
			out_data.first_axis_y  <= so.a1.y;
			out_data.first_axis_z  <= so.a1.z;
			out_data.second_axis_x <= n2_vec.x;
			out_data.second_axis_y <= n2_vec.y;
			out_data.second_axis_z <= n2_vec.z;
			out_data.back_axis_x   <= neg_sat(so.n.x);
			out_data.back_axis_y   <= neg_sat(so.n.y);
			out_data.back_axis_z   <= neg_sat(so.n.z);
			out_data.origin_x      <= so.tx;
			out_data.origin_y      <= so.ty;
			out_data.origin_z      <= so.tz;
		end
	end

`ifndef ASSERT_OFF
	// one of the first axis x or y is always zero by construction
	a_first_axis_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.first_axis_x == '0 || out_data.first_axis_y == '0))
		else $error("first axis has both x and y set");

	// a zero normal gives zero axes
	a_zero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.back_axis_x == '0 && out_data.back_axis_y == '0
			&& out_data.back_axis_z == '0)
		|-> (out_data.first_axis_x == '0 && out_data.first_axis_z == '0
			&& out_data.second_axis_x == '0 && out_data.second_axis_y == '0
			&& out_data.second_axis_z == '0))
		else $error("zero normal produced nonzero axis");

	// a stall must keep out_valid set and hold the last sideband stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(side2_s[NORM_LAT])))
		else $error("pipeline advanced during stall");
`endif

endmodule
